@@ hw/rtl/imh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imh_pkg
// shared constants and codes for the indexed max-heap
// ----------------------------------------------------------------------------
package imh_pkg;

	// handle space is fixed by the handle field
	localparam int HANDLES  = 1024;
	localparam int HANDLE_W = 10;
	localparam int FUNC_W   = 2;

	// defaults for the top-level parameters
	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_BITS_DEF = 32;

	// operation codes, code 3 is a no-op
	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT  = 2'd0,
		FUNC_EXTRACT = 2'd1,
		FUNC_DELETE  = 2'd2
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

endpackage
`default_nettype wire

@@ hw/rtl/imh_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imh_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ hw/rtl/imh_cmp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imh_cmp
// shared signed key comparator, strict greater-than
// ----------------------------------------------------------------------------
module imh_cmp #(
	parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
	input  logic signed [KEY_BITS-1:0] a,
	input  logic signed [KEY_BITS-1:0] b,
	output logic                       gt
);

	// most negative code is just the smallest key
	assign gt = (a > b);

endmodule
`default_nettype wire

@@ hw/rtl/indexed_max_heap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_max_heap
// indexed binary max-heap of handles keyed by signed fixed-point scores
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------
//  request  | in        | req_valid, req_stall | func, handle, key
//  response | out       | rsp_valid, rsp_stall | status, out_handle, out_key, count
//
// one beat at a time: insert climbs from the new last slot, reading the parent and
// comparing once per level; extract drops the root, moves the last slot to the top
// and sinks it, reading the left child, then the right child, per level; delete
// first raises its slot to the root, moving each parent down, then extracts. the
// next beat is taken in the cycle after the result is loaded. the single read port
// of the slot memory and the one shared comparator make these steps serial.
// after reset the present map is swept, one handle per cycle, with req_stall high.
// a finished result waits in the response register; the next request is taken
// meanwhile and only its own result waits on rsp_stall.
//
module indexed_max_heap #(
	parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [imh_pkg::FUNC_W-1:0]          func,
	input  logic [imh_pkg::HANDLE_W-1:0]        handle,
	input  logic signed [KEY_BITS-1:0]          key,
	// response channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output imh_pkg::status_t                    status,
	output logic [imh_pkg::HANDLE_W-1:0]        out_handle,
	output logic signed [KEY_BITS-1:0]          out_key,
	output logic [$clog2(CAPACITY+1)-1:0]       count
);

	import imh_pkg::*;

	localparam int SLOT_W  = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int CHILD_W = SLOT_W + 2;        // holds right child index of last slot
	localparam int SLOT_DW = HANDLE_W + KEY_BITS;

	// sequencer states
	typedef enum logic [3:0] {
		S_CLEAR,      // sweep present map after reset
		S_IDLE,       // wait for request, root/present/where reads issued
		S_DECODE,     // check flags, pick the operation path
		S_DEL_RD,     // read the slot of the handle being deleted
		S_DEL_GET,    // capture deleted element
		S_RAISE_RD,   // read parent while raising toward the root
		S_RAISE_WR,   // shift parent one level down
		S_UP_RD,      // read parent during sift-up
		S_UP_CMP,     // compare with parent, shift or place
		S_TAKE,       // drop root, read last slot
		S_TAKE_LAST,  // last slot becomes the moving element
		S_DN_RDL,     // read left child during sift-down
		S_DN_RDR,     // compare left child, read right child
		S_DN_CMPR,    // compare right child and act
		S_DN_ACT,     // act on left-only result
		S_FINISH      // load response register
	} state_t;

	state_t                      state_q;
	logic [HANDLE_W-1:0]         clr_q;
	logic [CNT_W-1:0]            fill_q;
	logic [SLOT_W-1:0]           pos_q;      // current hole in the heap
	logic [FUNC_W-1:0]           func_q;
	logic [HANDLE_W-1:0]         hdl_q;
	logic [HANDLE_W-1:0]         mv_h_q;     // element being sifted
	logic signed [KEY_BITS-1:0]  mv_k_q;
	logic [HANDLE_W-1:0]         rm_h_q;     // element being removed
	logic signed [KEY_BITS-1:0]  rm_k_q;
	logic                        rm_q;
	status_t                     st_q;
	logic                        big_child_q; // left child beat the moving element
	logic [HANDLE_W-1:0]         big_h_q;
	logic signed [KEY_BITS-1:0]  big_k_q;
	logic [SLOT_W-1:0]           big_pos_q;
	logic                        rsp_valid_q;
	status_t                     status_q;
	logic [HANDLE_W-1:0]         out_handle_q;
	logic signed [KEY_BITS-1:0]  out_key_q;
	logic [CNT_W-1:0]            count_q;

	// memory ports
	logic                        slot_we;
	logic [SLOT_W-1:0]           slot_waddr;
	logic [SLOT_DW-1:0]          slot_wdata;
	logic [SLOT_W-1:0]           slot_raddr;
	logic [SLOT_DW-1:0]          slot_rdata;
	logic                        where_we;
	logic [HANDLE_W-1:0]         where_waddr;
	logic [SLOT_W-1:0]           where_wdata;
	logic [SLOT_W-1:0]           where_rdata;
	logic                        present_we;
	logic [HANDLE_W-1:0]         present_waddr;
	logic [0:0]                  present_wdata;
	logic [0:0]                  present_rdata;

	// slot word split
	logic [HANDLE_W-1:0]         rd_h;
	logic signed [KEY_BITS-1:0]  rd_k;

	// index arithmetic
	logic [SLOT_W-1:0]           parent;
	logic [CHILD_W-1:0]          child_l;
	logic [CHILD_W-1:0]          child_r;
	logic [CHILD_W-1:0]          fill_x;
	logic                        l_in;
	logic                        r_in;
	logic [CNT_W-1:0]            fill_dec;
	logic                        full;
	logic                        where_ok;

	// shared comparator
	logic signed [KEY_BITS-1:0]  cmp_a;
	logic signed [KEY_BITS-1:0]  cmp_b;
	logic                        cmp_gt;

	// sift-down decision
	logic                        act_child;
	logic [HANDLE_W-1:0]         act_h;
	logic signed [KEY_BITS-1:0]  act_k;
	logic [SLOT_W-1:0]           act_pos;

	// response register takes a new result
	logic                        rsp_load;

	assign rd_h = slot_rdata[KEY_BITS +: HANDLE_W];
	assign rd_k = slot_rdata[KEY_BITS-1:0];

	assign parent   = SLOT_W'((pos_q - SLOT_W'(1)) >> 1);
	assign child_l  = {1'b0, pos_q, 1'b1};
	assign child_r  = child_l + CHILD_W'(1);
	assign fill_x   = CHILD_W'(fill_q);
	assign l_in     = (child_l < fill_x);
	assign r_in     = (child_r < fill_x);
	assign fill_dec = fill_q - CNT_W'(1);
	assign full     = (fill_q == CNT_W'(CAPACITY));
	// a stale map entry can point past the filled part
	assign where_ok = (CNT_W'(where_rdata) < fill_q);

	// load only while the older result is gone or leaves on this edge
	assign rsp_load = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);

	// sift-up compares moving element against parent,
	// sift-down compares children against the current best
	always_comb begin
		cmp_a = rd_k;
		cmp_b = mv_k_q;
		if (state_q == S_UP_CMP) begin
			cmp_a = mv_k_q;
			cmp_b = rd_k;
		end else if (state_q == S_DN_CMPR) begin
			cmp_b = big_k_q;
		end
	end

	imh_cmp #(
		.KEY_BITS(KEY_BITS)
	) u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.gt (cmp_gt)
	);

	// right child replaces the best only when strictly greater, so left wins ties
	always_comb begin
		if (state_q == S_DN_CMPR && cmp_gt) begin
			act_child = 1'b1;
			act_h     = rd_h;
			act_k     = rd_k;
			act_pos   = child_r[SLOT_W-1:0];
		end else begin
			act_child = big_child_q;
			act_h     = big_h_q;
			act_k     = big_k_q;
			act_pos   = big_pos_q;
		end
	end

	// memory port control
	always_comb begin
		slot_we       = 1'b0;
		slot_waddr    = pos_q;
		slot_wdata    = {mv_h_q, mv_k_q};
		slot_raddr    = '0;
		where_we      = 1'b0;
		where_waddr   = mv_h_q;
		where_wdata   = pos_q;
		present_we    = 1'b0;
		present_waddr = hdl_q;
		present_wdata = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				present_we    = 1'b1;
				present_waddr = clr_q;
			end
			S_DECODE: begin
				if (func_q == FUNC_INSERT && !full && !present_rdata[0]) begin
					present_we    = 1'b1;
					present_wdata = 1'b1;
				end
			end
			S_DEL_RD: begin
				slot_raddr = pos_q;
			end
			S_RAISE_RD: begin
				if (pos_q != '0) begin
					slot_raddr = parent;
				end
			end
			S_RAISE_WR: begin
				// parent moves down into the hole
				slot_we     = 1'b1;
				slot_wdata  = slot_rdata;
				where_we    = 1'b1;
				where_waddr = rd_h;
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					slot_we  = 1'b1;
					where_we = 1'b1;
				end else begin
					slot_raddr = parent;
				end
			end
			S_UP_CMP: begin
				slot_we  = 1'b1;
				where_we = 1'b1;
				if (cmp_gt) begin
					slot_wdata  = slot_rdata;
					where_waddr = rd_h;
				end
			end
			S_TAKE: begin
				present_we    = 1'b1;
				present_waddr = rm_h_q;
				slot_raddr    = fill_dec[SLOT_W-1:0];
			end
			S_DN_RDL: begin
				if (!l_in) begin
					slot_we  = 1'b1;
					where_we = 1'b1;
				end else begin
					slot_raddr = child_l[SLOT_W-1:0];
				end
			end
			S_DN_RDR: begin
				if (r_in) begin
					slot_raddr = child_r[SLOT_W-1:0];
				end
			end
			S_DN_CMPR, S_DN_ACT: begin
				slot_we  = 1'b1;
				where_we = 1'b1;
				if (act_child) begin
					slot_wdata  = {act_h, act_k};
					where_waddr = act_h;
				end
			end
			default: begin
			end
		endcase
	end

	// handle and key of each slot
	imh_ram #(
		.WIDTH(SLOT_DW),
		.DEPTH(CAPACITY)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// slot of each handle, read straight from the request port while idle
	imh_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(HANDLES)
	) u_where_ram (
		.clk   (clk),
		.we    (where_we),
		.waddr (where_waddr),
		.wdata (where_wdata),
		.raddr (handle),
		.rdata (where_rdata)
	);

	// present flag of each handle
	imh_ram #(
		.WIDTH(1),
		.DEPTH(HANDLES)
	) u_present_ram (
		.clk   (clk),
		.we    (present_we),
		.waddr (present_waddr),
		.wdata (present_wdata),
		.raddr (handle),
		.rdata (present_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			fill_q       <= '0;
			pos_q        <= '0;
			func_q       <= '0;
			hdl_q        <= '0;
			mv_h_q       <= '0;
			mv_k_q       <= '0;
			rm_h_q       <= '0;
			rm_k_q       <= '0;
			rm_q         <= 1'b0;
			st_q         <= ST_OK;
			big_child_q  <= 1'b0;
			big_h_q      <= '0;
			big_k_q      <= '0;
			big_pos_q    <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			out_handle_q <= '0;
			out_key_q    <= '0;
			count_q      <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + HANDLE_W'(1);
					if (clr_q == HANDLE_W'(HANDLES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						func_q  <= func;
						hdl_q   <= handle;
						mv_h_q  <= handle;
						mv_k_q  <= key;
						rm_q    <= 1'b0;
						st_q    <= ST_OK;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (func_q)
						FUNC_INSERT: begin
							// fullness is checked before duplicates
							if (full) begin
								st_q    <= ST_FULL;
								state_q <= S_FINISH;
							end else if (present_rdata[0]) begin
								st_q    <= ST_ABSENT;
								state_q <= S_FINISH;
							end else begin
								fill_q  <= fill_q + CNT_W'(1);
								pos_q   <= fill_q[SLOT_W-1:0];
								state_q <= S_UP_RD;
							end
						end
						FUNC_EXTRACT: begin
							if (fill_q == '0) begin
								st_q    <= ST_EMPTY;
								state_q <= S_FINISH;
							end else begin
								rm_h_q  <= rd_h;
								rm_k_q  <= rd_k;
								rm_q    <= 1'b1;
								state_q <= S_TAKE;
							end
						end
						FUNC_DELETE: begin
							if (!present_rdata[0] || !where_ok) begin
								st_q    <= ST_ABSENT;
								state_q <= S_FINISH;
							end else begin
								pos_q   <= where_rdata;
								state_q <= S_DEL_RD;
							end
						end
						default: begin
							state_q <= S_FINISH;
						end
					endcase
				end
				S_DEL_RD: begin
					state_q <= S_DEL_GET;
				end
				S_DEL_GET: begin
					rm_h_q  <= rd_h;
					rm_k_q  <= rd_k;
					rm_q    <= 1'b1;
					state_q <= S_RAISE_RD;
				end
				S_RAISE_RD: begin
					state_q <= (pos_q == '0) ? S_TAKE : S_RAISE_WR;
				end
				S_RAISE_WR: begin
					pos_q   <= parent;
					state_q <= S_RAISE_RD;
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_FINISH : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_gt) begin
						pos_q   <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_TAKE: begin
					fill_q  <= fill_dec;
					state_q <= (fill_dec == '0) ? S_FINISH : S_TAKE_LAST;
				end
				S_TAKE_LAST: begin
					mv_h_q  <= rd_h;
					mv_k_q  <= rd_k;
					pos_q   <= '0;
					state_q <= S_DN_RDL;
				end
				S_DN_RDL: begin
					state_q <= l_in ? S_DN_RDR : S_FINISH;
				end
				S_DN_RDR: begin
					big_child_q <= cmp_gt;
					big_h_q     <= cmp_gt ? rd_h : mv_h_q;
					big_k_q     <= cmp_gt ? rd_k : mv_k_q;
					big_pos_q   <= child_l[SLOT_W-1:0];
					state_q     <= r_in ? S_DN_CMPR : S_DN_ACT;
				end
				S_DN_CMPR, S_DN_ACT: begin
					if (act_child) begin
						pos_q   <= act_pos;
						state_q <= S_DN_RDL;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					// hold here while an older result is still stalled
					if (rsp_load) begin
						status_q     <= st_q;
						out_handle_q <= rm_q ? rm_h_q : '0;
						out_key_q    <= rm_q ? rm_k_q : '0;
						count_q      <= fill_q;
						state_q      <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign out_handle = out_handle_q;
	assign out_key    = out_key_q;
	assign count      = count_q;

endmodule
`default_nettype wire
